[rtl/core/plid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list package
// Shared widths, status codes, mode codes and the operation struct that the
// control logic broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package plid_pkg;

    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic ins;
        logic del;
    } plid_op_t;

endpackage

[rtl/core/plid_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list storage cell
// Holds one list entry, compares its own place with the target index and
// takes its left neighbor, its right neighbor or the new value.
// ----------------------------------------------------------------------------
module plid_cell #(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  logic                                 clk,
    input  plid_pkg::plid_op_t                   op,
    input  logic [IDX_W-1:0]                     target,
    input  logic signed [plid_pkg::VALUE_W-1:0]  item_value,
    input  logic signed [plid_pkg::VALUE_W-1:0]  left_value,
    input  logic signed [plid_pkg::VALUE_W-1:0]  right_value,
    output logic signed [plid_pkg::VALUE_W-1:0]  entry,
    output logic signed [plid_pkg::VALUE_W-1:0]  tap
);
    import plid_pkg::*;

    localparam logic [IDX_W-1:0] HERE = IDX_W'(INDEX);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.ins)
        begin
            if (HERE > target)
            begin
                entry_next = left_value;
            end
            else if (HERE == target)
            begin
                entry_next = item_value;
            end
        end
        else if (op.del)
        begin
            if (HERE >= target)
            begin
                entry_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign tap   = (op.del && (HERE == target)) ? entry_reg : '0;

endmodule

[rtl/core/positional_list_insert_delete_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list insert/delete unit
// Ordered list of signed 32-bit values held in a row of cells. Inserts shift
// later entries up, deletes shift them down and return the removed value.
//
//   Channel   Handshake            Payload
//   command   start / busy         mode, list_position, item_value
//   result    done (strobe)        removed_value, status, list_length
//
// Every cell updates in the cycle a transaction is accepted, so one
// transaction is taken per clock and its result appears in the cycle after.
// The shift is done by all cells at once; the removed value is collected
// from the cell taps in the same cycle.
// Reset empties the list; busy is always low and the receiver cannot stall.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 mode,
    input  logic [plid_pkg::POS_W-1:0]           list_position,
    input  logic signed [plid_pkg::VALUE_W-1:0]  item_value,
    output logic                                 done,
    output logic signed [plid_pkg::VALUE_W-1:0]  removed_value,
    output plid_pkg::status_t                    status,
    output logic [plid_pkg::LEN_W-1:0]           list_length
);
    import plid_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic                      done_reg;
    logic signed [VALUE_W-1:0] removed_reg;
    logic signed [VALUE_W-1:0] removed_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    logic                      accept;
    logic [CMP_W-1:0]          pos_w;
    logic [CMP_W-1:0]          pos_dec;
    logic [CMP_W-1:0]          cnt_w;
    logic [CMP_W-1:0]          len_w;
    logic [IDX_W-1:0]          target;
    plid_op_t                  op;

    logic signed [VALUE_W-1:0] entries [CAPACITY];
    logic signed [VALUE_W-1:0] taps    [CAPACITY];
    logic signed [VALUE_W-1:0] tap_or;

    assign accept  = start && !busy;
    assign pos_w   = CMP_W'(list_position);
    assign pos_dec = pos_w - CMP_W'(1);
    assign cnt_w   = CMP_W'(count_reg);

    always_comb
    begin
        op          = '0;
        status_next = STATUS_DONE;
        count_next  = count_reg;
        target      = pos_w[IDX_W-1:0];
        if (mode == MODE_INSERT)
        begin
            if (pos_w > cnt_w)
            begin
                status_next = STATUS_RANGE;
            end
            else if (cnt_w == CMP_W'(CAPACITY))
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                op.ins     = accept;
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            target = pos_dec[IDX_W-1:0];
            if ((pos_w == '0) || (pos_w > cnt_w))
            begin
                status_next = STATUS_RANGE;
            end
            else
            begin
                op.del     = accept;
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [VALUE_W-1:0] left_value;
            logic signed [VALUE_W-1:0] right_value;

            if (gi == 0)
            begin : g_first
                assign left_value = item_value;
            end
            else
            begin : g_left
                assign left_value = entries[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_value = '0;
            end
            else
            begin : g_right
                assign right_value = entries[gi+1];
            end

            plid_cell #(
                .IDX_W (IDX_W),
                .INDEX (gi)
            ) u_cell (
                .clk         (clk),
                .op          (op),
                .target      (target),
                .item_value  (item_value),
                .left_value  (left_value),
                .right_value (right_value),
                .entry       (entries[gi]),
                .tap         (taps[gi])
            );
        end
    endgenerate

    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tap_or = tap_or | taps[i];
        end
    end

    assign removed_next = op.del ? tap_or : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            count_reg  <= '0;
            status_reg <= STATUS_DONE;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg  <= count_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg <= removed_next;
        end
    end

    assign len_w         = CMP_W'(count_reg);
    assign busy          = 1'b0;
    assign done          = done_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign list_length   = len_w[LEN_W-1:0];

endmodule

[rtl/core/plid_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list port checker
// Watches the top-level ports for result timing and result consistency.
// ----------------------------------------------------------------------------
module plid_port_checker #(
    parameter int CAPACITY = 64
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 mode,
    input logic [plid_pkg::POS_W-1:0]           list_position,
    input logic signed [plid_pkg::VALUE_W-1:0]  item_value,
    input logic                                 done,
    input logic signed [plid_pkg::VALUE_W-1:0]  removed_value,
    input plid_pkg::status_t                    status,
    input logic [plid_pkg::LEN_W-1:0]           list_length
);
    import plid_pkg::*;

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(CAPACITY);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("Accepted transaction produced no result.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("Result strobe without an accepted transaction.");

    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_FULL)) |-> (list_length == FULL_LEN))
        else $error("List full reported while the list is not full.");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_DONE)) |-> (removed_value == '0))
        else $error("Refused transaction returned a nonzero value.");

    a_insert_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(mode == MODE_INSERT)) |-> (removed_value == '0))
        else $error("Insert returned a nonzero removed value.");

endmodule

bind positional_list_insert_delete_unit plid_port_checker #(
    .CAPACITY (CAPACITY)
) u_plid_checker (.*);
